// ===== design/mlts_pkg.sv =====
// Shared types, token kind codes, character codes and keyword tables
// for the token scanner. No dependencies.
`default_nettype none

package mlts_pkg;

   localparam int LENGTH_LIMIT = 255;
   localparam int COUNT_W      = $clog2(LENGTH_LIMIT + 1);
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

   localparam logic [3:0] KIND_BEGIN  = 4'd0;
   localparam logic [3:0] KIND_END    = 4'd1;
   localparam logic [3:0] KIND_READ   = 4'd2;
   localparam logic [3:0] KIND_WRITE  = 4'd3;
   localparam logic [3:0] KIND_IDENT  = 4'd4;
   localparam logic [3:0] KIND_INTLIT = 4'd5;
   localparam logic [3:0] KIND_LPAREN = 4'd6;
   localparam logic [3:0] KIND_RPAREN = 4'd7;
   localparam logic [3:0] KIND_SEMI   = 4'd8;
   localparam logic [3:0] KIND_COMMA  = 4'd9;
   localparam logic [3:0] KIND_ASSIGN = 4'd10;
   localparam logic [3:0] KIND_PLUS   = 4'd11;
   localparam logic [3:0] KIND_MINUS  = 4'd12;
   localparam logic [3:0] KIND_EOS    = 4'd13;
   localparam logic [3:0] KIND_ERROR  = 4'd14;

   localparam logic [7:0] CHAR_NEWLINE    = 8'h0a;
   localparam logic [7:0] CHAR_LPAREN     = 8'h28;
   localparam logic [7:0] CHAR_RPAREN     = 8'h29;
   localparam logic [7:0] CHAR_PLUS       = 8'h2b;
   localparam logic [7:0] CHAR_COMMA      = 8'h2c;
   localparam logic [7:0] CHAR_DASH       = 8'h2d;
   localparam logic [7:0] CHAR_COLON      = 8'h3a;
   localparam logic [7:0] CHAR_SEMI       = 8'h3b;
   localparam logic [7:0] CHAR_EQUAL      = 8'h3d;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5f;

   // begin, end, read, write (lower case, zero padded)
   localparam logic [7:0] KW_TEXT [4][8] = '{
      '{8'h62, 8'h65, 8'h67, 8'h69, 8'h6e, 8'h00, 8'h00, 8'h00},
      '{8'h65, 8'h6e, 8'h64, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h72, 8'h65, 8'h61, 8'h64, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h77, 8'h72, 8'h69, 8'h74, 8'h65, 8'h00, 8'h00, 8'h00}
   };
   localparam logic [2:0] KW_LEN [4] = '{3'd5, 3'd3, 3'd4, 3'd5};

   typedef struct packed {
      logic [3:0] kind;
      logic [7:0] len;
      logic [7:0] err;
   } token_type;

   // One queue entry: the tokens caused by one input transfer.
   typedef struct packed {
      token_type tok0;
      token_type tok1;
      logic      two;
   } pair_type;

   function automatic logic kw_keep(input logic [1:0] k, input logic [COUNT_W-1:0] pos,
                                    input logic [7:0] low);
      logic keep;
      keep = 1'b0;
      if (pos < COUNT_W'(KW_LEN[k])) begin
         keep = (KW_TEXT[k][pos[2:0]] == low);
      end
      return keep;
   endfunction

   function automatic logic [7:0] sat_len(input logic [COUNT_W-1:0] count);
      logic [7:0] len;
      len = (count > COUNT_W'(8'hff)) ? 8'hff : 8'(count);
      return len;
   endfunction

endpackage

`default_nettype wire

// ===== design/mlts_front.sv =====
// Scanner front end: accepts source bytes, tracks lexeme state and
// classifies up to two tokens per byte into one queue entry. Uses mlts_pkg.
`default_nettype none

module mlts_front
   import mlts_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] char_code
   input  wire logic       req_tlast,   // end_of_input
   output logic            push_valid,
   output pair_type        push_data,
   input  wire logic       push_ready
);

   localparam logic [2:0] MODE_IDLE    = 3'd0;
   localparam logic [2:0] MODE_IDENT   = 3'd1;
   localparam logic [2:0] MODE_NUMBER  = 3'd2;
   localparam logic [2:0] MODE_COLON   = 3'd3;
   localparam logic [2:0] MODE_DASH    = 3'd4;
   localparam logic [2:0] MODE_COMMENT = 3'd5;

   logic [2:0]         mode_ff, mode_in;
   logic [COUNT_W-1:0] count_ff, count_in, count_inc;
   logic [3:0]         cand_ff, cand_in, cand_step, idle_cand;

   logic [7:0] c, low;
   logic       is_letter, is_digit, is_space, accept;

   token_type  idle_tok, ident_tok, f_tok, s_tok;
   logic       idle_emit, idle_start, f_emit, s_emit, use_idle;
   logic [2:0] idle_mode;

   assign c          = req_tdata;
   assign is_letter  = c inside {[8'h61:8'h7a], [8'h41:8'h5a]};
   assign is_digit   = c inside {[8'h30:8'h39]};
   assign is_space   = c inside {8'h20, [8'h09:8'h0d]};
   assign low        = (c inside {[8'h41:8'h5a]}) ? c + 8'h20 : c;
   assign req_tready = push_ready;
   assign accept     = req_tvalid & push_ready;
   assign count_inc  = (count_ff < COUNT_W'(LENGTH_LIMIT)) ? count_ff + COUNT_W'(1) : count_ff;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         cand_step[k] = cand_ff[k] & kw_keep(2'(k), count_ff, low);
         idle_cand[k] = kw_keep(2'(k), '0, low);
      end
   end

   always_comb begin
      ident_tok = '{kind: KIND_IDENT, len: sat_len(count_ff), err: 8'h00};
      for (int k = 0; k < 4; k++) begin
         if (cand_ff[k] && count_ff == COUNT_W'(KW_LEN[k])) begin
            ident_tok.kind = 4'(k);
         end
      end
   end

   // Scan of the byte from idle.
   always_comb begin
      idle_tok   = '{kind: KIND_ERROR, len: 8'h00, err: 8'h00};
      idle_emit  = 1'b1;
      idle_start = 1'b0;
      idle_mode  = MODE_IDLE;
      if (is_space) begin
         idle_emit = 1'b0;
      end else if (is_letter) begin
         idle_emit  = 1'b0;
         idle_start = 1'b1;
         idle_mode  = MODE_IDENT;
      end else if (is_digit) begin
         idle_emit  = 1'b0;
         idle_start = 1'b1;
         idle_mode  = MODE_NUMBER;
      end else begin
         case (c)
            CHAR_LPAREN: idle_tok.kind = KIND_LPAREN;
            CHAR_RPAREN: idle_tok.kind = KIND_RPAREN;
            CHAR_SEMI:   idle_tok.kind = KIND_SEMI;
            CHAR_COMMA:  idle_tok.kind = KIND_COMMA;
            CHAR_PLUS:   idle_tok.kind = KIND_PLUS;
            CHAR_COLON: begin
               idle_emit = 1'b0;
               idle_mode = MODE_COLON;
            end
            CHAR_DASH: begin
               idle_emit = 1'b0;
               idle_mode = MODE_DASH;
            end
            default: idle_tok.err = c;
         endcase
      end
   end

   always_comb begin
      mode_in  = mode_ff;
      count_in = count_ff;
      cand_in  = cand_ff;
      f_emit   = 1'b0;
      f_tok    = ident_tok;
      s_emit   = 1'b0;
      s_tok    = '{kind: KIND_EOS, len: 8'h00, err: 8'h00};
      use_idle = 1'b0;
      if (req_tlast) begin
         case (mode_ff)
            MODE_IDENT: f_emit = 1'b1;
            MODE_NUMBER: begin
               f_emit = 1'b1;
               f_tok  = '{kind: KIND_INTLIT, len: sat_len(count_ff), err: 8'h00};
            end
            MODE_COLON: begin
               f_emit = 1'b1;
               f_tok  = '{kind: KIND_ERROR, len: 8'h00, err: CHAR_COLON};
            end
            MODE_DASH: begin
               f_emit = 1'b1;
               f_tok  = '{kind: KIND_MINUS, len: 8'h00, err: 8'h00};
            end
            default: f_emit = 1'b0;
         endcase
         s_emit   = 1'b1;
         mode_in  = MODE_IDLE;
         count_in = '0;
         cand_in  = 4'hf;
      end else begin
         case (mode_ff)
            MODE_IDENT: begin
               if (is_letter || is_digit || c == CHAR_UNDERSCORE) begin
                  count_in = count_inc;
                  cand_in  = cand_step;
               end else begin
                  f_emit   = 1'b1;
                  use_idle = 1'b1;
               end
            end
            MODE_NUMBER: begin
               if (is_digit) begin
                  count_in = count_inc;
               end else begin
                  f_emit   = 1'b1;
                  f_tok    = '{kind: KIND_INTLIT, len: sat_len(count_ff), err: 8'h00};
                  use_idle = 1'b1;
               end
            end
            MODE_COLON: begin
               if (c == CHAR_EQUAL) begin
                  s_emit  = 1'b1;
                  s_tok   = '{kind: KIND_ASSIGN, len: 8'h00, err: 8'h00};
                  mode_in = MODE_IDLE;
               end else begin
                  f_emit   = 1'b1;
                  f_tok    = '{kind: KIND_ERROR, len: 8'h00, err: CHAR_COLON};
                  use_idle = 1'b1;
               end
            end
            MODE_DASH: begin
               if (c == CHAR_DASH) begin
                  mode_in = MODE_COMMENT;
               end else begin
                  f_emit   = 1'b1;
                  f_tok    = '{kind: KIND_MINUS, len: 8'h00, err: 8'h00};
                  use_idle = 1'b1;
               end
            end
            MODE_COMMENT: begin
               if (c == CHAR_NEWLINE) begin
                  mode_in = MODE_IDLE;
               end
            end
            default: use_idle = 1'b1;
         endcase
         if (use_idle) begin
            s_emit  = idle_emit;
            s_tok   = idle_tok;
            mode_in = idle_mode;
            if (idle_start) begin
               count_in = COUNT_W'(1);
               cand_in  = is_letter ? idle_cand : 4'hf;
            end
         end
      end
   end

   assign push_valid     = accept & (f_emit | s_emit);
   assign push_data.tok0 = f_emit ? f_tok : s_tok;
   assign push_data.tok1 = s_tok;
   assign push_data.two  = f_emit & s_emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         count_ff <= '0;
         cand_ff  <= 4'hf;
      end else if (accept) begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
         cand_ff  <= cand_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/mlts_queue.sv =====
// Short token-pair queue between scanner front end and output back end.
// Uses mlts_pkg.
`default_nettype none

module mlts_queue
   import mlts_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push_valid,
   input  wire pair_type push_data,
   output logic          push_ready,
   output logic          pop_valid,
   output pair_type      pop_data,
   input  wire logic     pop
);

   pair_type            entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]     fill_ff, fill_in;
   logic                do_push, do_pop;

   assign push_ready = (fill_ff != (QPTR_W + 1)'(QUEUE_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_data   = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop & pop_valid;

   always_comb begin
      fill_in = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + (QPTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - (QPTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         fill_ff <= fill_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
      end
   end

endmodule

`default_nettype wire

// ===== design/mlts_back.sv =====
// Output back end: splits each queued token pair into single token
// transfers held in an output register. Uses mlts_pkg.
`default_nettype none

module mlts_back
   import mlts_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        pop_valid,
   input  wire pair_type    pop_data,
   output logic             pop,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,  // [7:0] lexeme_length, [15:8] error_char
   output logic [3:0]       rsp_tuser,  // [3:0] token_kind
   output logic             rsp_tlast   // last_of_run
);

   logic      valid_ff, second_ff, last_ff, load;
   token_type tok_ff;

   assign load       = pop_valid & (~valid_ff | rsp_tready);
   assign pop        = load & (second_ff | ~pop_data.two);
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {tok_ff.err, tok_ff.len};
   assign rsp_tuser  = tok_ff.kind;
   assign rsp_tlast  = last_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         tok_ff  <= second_ff ? pop_data.tok1 : pop_data.tok0;
         last_ff <= second_ff | ~pop_data.two;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         if (load) begin
            valid_ff  <= 1'b1;
            second_ff <= ~second_ff & pop_data.two;
         end else if (rsp_tready) begin
            valid_ff <= 1'b0;
         end
      end
   end

endmodule

`default_nettype wire

// ===== design/micro_language_token_scanner.sv =====
// Token scanner top level: one source byte per transfer in, one token per transfer out.
// Each token passes the pair queue and the output register. Throughput: one byte per
// cycle unless the queue is full; output one token per cycle unless stalled; a byte that
// yields two tokens takes two output transfers, absorbed by the four-entry pair queue.
// Reset (synchronous): scanner returns to idle, queue and output register empty.
// Instantiates mlts_front, mlts_queue, mlts_back; uses mlts_pkg.
`default_nettype none

module micro_language_token_scanner
   import mlts_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] char_code
   input  wire logic        req_tlast,   // end_of_input
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [7:0] lexeme_length, [15:8] error_char
   output logic [3:0]       rsp_tuser,   // [3:0] token_kind
   output logic             rsp_tlast    // last_of_run
);

   logic     push_valid, push_ready, pop_valid, pop;
   pair_type push_data, pop_data;

   mlts_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready)
   );

   mlts_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop        (pop)
   );

   mlts_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire
